// ----- hw/rtl/cir_pkg.sv -----
// Package for the cubic interpolation resampler: parameter defaults, register
// indexes and reset values, digit size of the serial MAC, MAC request struct.
// No dependencies.
package cir_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_RUN_DEF     = 64;

	// serial MAC consumes one multiplier digit of this many bits per cycle
	localparam int DIGIT_BITS = 4;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN            = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT        = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE     = 4'd3;

	localparam int INC_W  = 20;
	localparam int GAIN_W = 16;
	localparam int PAN_W  = 17;

	localparam logic [INC_W-1:0]  INC_RESET    = 20'd65536;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd16384;
	localparam logic [PAN_W-1:0]  PAN_RESET    = 17'd32768;
	localparam logic              STEREO_RESET = 1'b1;

	localparam logic [INC_W-1:0] MIN_INCREMENT = 20'd2048;
	localparam logic [PAN_W-1:0] PAN_ONE       = 17'd65536;

	localparam int GAIN_SHIFT = 14;
	localparam int PAN_SHIFT  = 16;

	typedef struct packed {
		logic start;
		logic clear;
	} mac_req_t;

endpackage

// ----- hw/rtl/cir_ifs.sv -----
// Valid/ready channel interfaces of the resampler: sample input, result output
// and configuration write. Depends on cir_pkg for the configuration widths.
interface cir_sample_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface cir_result_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          last_of_run;

	modport source (output valid, output left_out, output right_out, output last_of_run,
		input ready);
	modport sink   (input valid, input left_out, input right_out, input last_of_run,
		output ready);
endinterface

interface cir_cfg_if;
	import cir_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/cir_mac.sv -----
// Digit-serial multiply-accumulate: acc (+)= a * b, one DIGIT_BITS digit of b
// per cycle, LSB first, stopping once the remaining multiplier is zero.
// Depends on cir_pkg (DIGIT_BITS, mac_req_t).
module cir_mac #(
	parameter int AW = 27,
	parameter int BW = 17,
	parameter int PW = 46
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cir_pkg::mac_req_t    req,
	input  logic signed [AW-1:0] a,
	input  logic [BW-1:0]        b,
	output logic [PW-1:0]        acc,
	output logic                 done
);
	import cir_pkg::*;

	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] acc_q;
	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] digit_w;

	assign digit_w = {{(PW-DIGIT_BITS){1'b0}}, b_q[DIGIT_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= PW'(a);
				b_q    <= b;
				busy_q <= 1'b1;
				if (req.clear) begin
					acc_q <= '0;
				end
			end else if (busy_q) begin
				if (b_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					// two's complement wraps correctly for a signed multiplicand
					acc_q <= acc_q + a_q * digit_w;
					a_q   <= a_q << DIGIT_BITS;
					b_q   <= b_q >> DIGIT_BITS;
				end
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ----- hw/rtl/cubic_interp_resampler_core.sv -----
// Cubic Lagrange interpolating resampler, top level: config registers, history,
// phase, operation sequencer, divide-by-3 unit and output register.
// Depends on cir_pkg, cir_ifs (channel interfaces) and cir_mac.
//
//   channel     dir  payload                                   handshake
//   sample_ch   in   sample_in                                 valid/ready
//   result_ch   out  left_out, right_out, last_of_run          valid/ready
//   cfg_ch      in   index, data                               valid/ready (ready = 1)
//
// An input is accepted in the idle state; each result it causes is computed on the
// shared digit-serial MAC (14 multiplies in stereo, 12 in mono) with two divide-by-3
// passes, then written to the output register before the next result restarts.
// Reset clears history, phase and registers to defaults; no clearing pass.
// A stalled result holds in the output register; the sequencer waits only when
// a second result is ready, and the next sample is taken as soon as a run ends.
module cubic_interp_resampler_core #(
	parameter int SAMPLE_BITS = cir_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = cir_pkg::FRAC_BITS_DEF,
	parameter int MAX_RUN     = cir_pkg::MAX_RUN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cir_sample_if.sink  sample_ch,
	cir_result_if.source result_ch,
	cir_cfg_if.sink     cfg_ch
);
	import cir_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int SB    = SAMPLE_BITS;
	localparam int PH_W  = F + 6;
	localparam int WW    = F + 1;
	localparam int VW    = SB + 2;
	localparam int GW    = SB + 4;
	localparam int AW    = (F + 3 > SB + 4) ? F + 3 : SB + 4;
	localparam int BW    = (F + 1 > PAN_W) ? F + 1 : PAN_W;
	localparam int PW_A  = (2 * F + 4 > SB + F + 4) ? 2 * F + 4 : SB + F + 4;
	localparam int PW    = (PW_A > SB + 22) ? PW_A : SB + 22;
	localparam int ZW    = F + 1;
	localparam int DIV_DIGITS = (ZW + 1) / 2;
	localparam int DZW   = 2 * DIV_DIGITS;
	localparam int DCNT_W = $clog2(DIV_DIGITS);
	localparam int RUN_W = $clog2(MAX_RUN + 1);

	localparam logic [PH_W-1:0] ONE_PH = {{(PH_W-F-1){1'b0}}, 1'b1, {F{1'b0}}};

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	localparam logic [3:0] OP_TQ   = 4'd0;
	localparam logic [3:0] OP_SQ   = 4'd1;
	localparam logic [3:0] OP_ST   = 4'd2;
	localparam logic [3:0] OP_WM2  = 4'd3;
	localparam logic [3:0] OP_WM1  = 4'd4;
	localparam logic [3:0] OP_WP1  = 4'd5;
	localparam logic [3:0] OP_WP2  = 4'd6;
	localparam logic [3:0] OP_H3   = 4'd7;
	localparam logic [3:0] OP_H2   = 4'd8;
	localparam logic [3:0] OP_H1   = 4'd9;
	localparam logic [3:0] OP_H0   = 4'd10;
	localparam logic [3:0] OP_GAIN = 4'd11;
	localparam logic [3:0] OP_PANL = 4'd12;
	localparam logic [3:0] OP_PANR = 4'd13;

	function automatic logic [SB-1:0] sat(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[SB-1:0];
		end else if (x < lo) begin
			return lo[SB-1:0];
		end
		return x[SB-1:0];
	endfunction

	// configuration
	logic [INC_W-1:0]  inc_q;
	logic [GAIN_W-1:0] gain_q;
	logic [PAN_W-1:0]  pan_q;
	logic              stereo_q;

	// sequencer and state
	logic [2:0]           state_q;
	logic [3:0]           op_q;
	logic [PH_W-1:0]      phase_q;
	logic [RUN_W-1:0]     n_q;
	logic signed [SB-1:0] hist_q [4];

	// intermediate products
	logic [WW-1:0]        tq_q, sq_q, st_q;
	logic [WW-1:0]        wm2_q, wm1_q, wp1_q, wp2_q;
	logic signed [GW-1:0] g_q;
	logic [SB-1:0]        left_q, right_q;

	// divide-by-3 unit
	logic [DZW-1:0]    div_z_q;
	logic [DZW-1:0]    div_quo_q;
	logic [1:0]        div_rem_q;
	logic [DCNT_W-1:0] div_cnt_q;

	// MAC request
	mac_req_t             mac_req_q;
	logic signed [AW-1:0] mac_a_q;
	logic [BW-1:0]        mac_b_q;
	logic [PW-1:0]        mac_acc;
	logic                 mac_done;

	// output register
	logic          out_valid_q;
	logic [SB-1:0] out_left_q, out_right_q;
	logic          out_last_q;

	cir_mac #(
		.AW(AW),
		.BW(BW),
		.PW(PW)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mac_req_q),
		.a     (mac_a_q),
		.b     (mac_b_q),
		.acc   (mac_acc),
		.done  (mac_done)
	);

	// operand and phase arithmetic
	logic [INC_W-1:0]     inc_c;
	logic [F+19:0]        inc_wide;
	logic [PH_W-1:0]      inc_f;
	logic [PAN_W-1:0]     pan_c, pan_r;
	logic [PH_W-1:0]      ph_under, ph_next;
	logic [RUN_W-1:0]     n_next;
	logic                 last_w;
	logic [F-1:0]         t_w;
	logic [F:0]           q_w, s_w;
	logic [F+1:0]         r_w;
	logic [PW-1:0]        rnd_f, rnd_w, rnd_z, rnd_g, rnd_p;
	logic signed [VW-1:0] v_w;
	logic signed [GW-1:0] g_w;
	logic [3:0]           div_val;
	logic [1:0]           div_dig;
	logic [1:0]           div_rem_nxt;
	logic [DZW-1:0]       div_quo_nxt;

	always_comb begin
		inc_c    = (inc_q < MIN_INCREMENT) ? MIN_INCREMENT : inc_q;
		inc_wide = {{F{1'b0}}, inc_c} << F;
		inc_f    = PH_W'(inc_wide[F+19:16]);
		pan_c    = (pan_q > PAN_ONE) ? PAN_ONE : pan_q;
		pan_r    = PAN_ONE - pan_c;
		ph_under = (phase_q >= ONE_PH) ? phase_q - ONE_PH : '0;
		ph_next  = phase_q + inc_f;
		n_next   = n_q + RUN_W'(1);
		last_w   = !((ph_next < ONE_PH) && (n_next < RUN_W'(MAX_RUN)));

		// while a run is active the phase is below one, so its low bits are t
		t_w = phase_q[F-1:0];
		q_w = {1'b1, {F{1'b0}}} - {1'b0, t_w};
		r_w = {2'b10, {F{1'b0}}} - {2'b00, t_w};
		s_w = {1'b1, t_w};

		rnd_f = mac_acc + (PW'(1) << (F - 1));
		rnd_w = mac_acc + (PW'(1) << F);
		rnd_z = mac_acc + (PW'(3) << F);
		rnd_g = mac_acc + (PW'(1) << (GAIN_SHIFT - 1));
		rnd_p = mac_acc + (PW'(1) << (PAN_SHIFT - 1));
		v_w   = VW'(signed'(rnd_f) >>> F);
		g_w   = GW'(signed'(rnd_g) >>> GAIN_SHIFT);

		// radix-4 long division by 3, MSB digit first
		div_val = {div_rem_q, div_z_q[DZW-1 -: 2]};
		if (div_val >= 4'd9) begin
			div_dig = 2'd3;
		end else if (div_val >= 4'd6) begin
			div_dig = 2'd2;
		end else if (div_val >= 4'd3) begin
			div_dig = 2'd1;
		end else begin
			div_dig = 2'd0;
		end
		div_rem_nxt = 2'(div_val - 4'(div_dig) * 4'd3);
		div_quo_nxt = {div_quo_q[DZW-3:0], div_dig};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q       <= INC_RESET;
			gain_q      <= GAIN_RESET;
			pan_q       <= PAN_RESET;
			stereo_q    <= STEREO_RESET;
			state_q     <= S_IDLE;
			op_q        <= OP_TQ;
			phase_q     <= '0;
			n_q         <= '0;
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= '0;
			end
			tq_q        <= '0;
			sq_q        <= '0;
			st_q        <= '0;
			wm2_q       <= '0;
			wm1_q       <= '0;
			wp1_q       <= '0;
			wp2_q       <= '0;
			g_q         <= '0;
			left_q      <= '0;
			right_q     <= '0;
			div_z_q     <= '0;
			div_quo_q   <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			mac_req_q   <= '0;
			mac_a_q     <= '0;
			mac_b_q     <= '0;
			out_valid_q <= 1'b0;
			out_left_q  <= '0;
			out_right_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			mac_req_q <= '0;
			if (out_valid_q && result_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					REG_PHASE_INCREMENT: inc_q <= cfg_ch.data[INC_W-1:0];
					REG_GAIN: gain_q <= cfg_ch.data[GAIN_W-1:0];
					REG_PAN_LEFT: pan_q <= cfg_ch.data[PAN_W-1:0];
					REG_STEREO_MODE: stereo_q <= cfg_ch.data[0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (sample_ch.valid) begin
						hist_q[3] <= hist_q[2];
						hist_q[2] <= hist_q[1];
						hist_q[1] <= hist_q[0];
						hist_q[0] <= sample_ch.sample_in;
						phase_q   <= ph_under;
						n_q       <= '0;
						state_q   <= (ph_under < ONE_PH) ? S_START : S_IDLE;
					end
				end
				S_START: begin
					mac_req_q <= '{start: 1'b1, clear: 1'b1};
					mac_a_q   <= AW'(t_w);
					mac_b_q   <= BW'(q_w);
					op_q      <= OP_TQ;
					state_q   <= S_RUN;
				end
				S_RUN: begin
					if (mac_done) begin
						case (op_q)
							OP_TQ: begin
								tq_q      <= WW'(rnd_f >> F);
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(s_w);
								mac_b_q   <= BW'(q_w);
								op_q      <= OP_SQ;
							end
							OP_SQ: begin
								sq_q      <= WW'(rnd_f >> F);
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(s_w);
								mac_b_q   <= BW'(t_w);
								op_q      <= OP_ST;
							end
							OP_ST: begin
								st_q      <= WW'(rnd_f >> F);
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(r_w);
								mac_b_q   <= BW'(tq_q);
								op_q      <= OP_WM2;
							end
							OP_WM2, OP_WP2: begin
								// (p + 3S) / 6S = ((p + 3S) >> (F+1)) / 3
								div_z_q   <= DZW'(rnd_z >> (F + 1));
								div_quo_q <= '0;
								div_rem_q <= '0;
								div_cnt_q <= '0;
								state_q   <= S_DIV;
							end
							OP_WM1: begin
								wm1_q     <= WW'(rnd_w >> (F + 1));
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(r_w);
								mac_b_q   <= BW'(st_q);
								op_q      <= OP_WP1;
							end
							OP_WP1: begin
								wp1_q     <= WW'(rnd_w >> (F + 1));
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(q_w);
								mac_b_q   <= BW'(st_q);
								op_q      <= OP_WP2;
							end
							OP_H3: begin
								mac_req_q <= '{start: 1'b1, clear: 1'b0};
								mac_a_q   <= AW'(hist_q[1]);
								mac_b_q   <= BW'(wp1_q);
								op_q      <= OP_H1;
							end
							OP_H1: begin
								mac_req_q <= '{start: 1'b1, clear: 1'b0};
								mac_a_q   <= AW'(hist_q[2]);
								mac_b_q   <= BW'(wm1_q);
								op_q      <= OP_H2;
							end
							OP_H2: begin
								mac_req_q <= '{start: 1'b1, clear: 1'b0};
								mac_a_q   <= -AW'(hist_q[0]);
								mac_b_q   <= BW'(wp2_q);
								op_q      <= OP_H0;
							end
							OP_H0: begin
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(v_w);
								mac_b_q   <= BW'(gain_q);
								op_q      <= OP_GAIN;
							end
							OP_GAIN: begin
								g_q <= g_w;
								if (stereo_q) begin
									mac_req_q <= '{start: 1'b1, clear: 1'b1};
									mac_a_q   <= AW'(g_w);
									mac_b_q   <= BW'(pan_c);
									op_q      <= OP_PANL;
								end else begin
									left_q  <= sat(PW'(g_w));
									right_q <= '0;
									state_q <= S_OUT;
								end
							end
							OP_PANL: begin
								left_q    <= sat(signed'(rnd_p) >>> PAN_SHIFT);
								mac_req_q <= '{start: 1'b1, clear: 1'b1};
								mac_a_q   <= AW'(g_q);
								mac_b_q   <= BW'(pan_r);
								op_q      <= OP_PANR;
							end
							OP_PANR: begin
								right_q <= sat(signed'(rnd_p) >>> PAN_SHIFT);
								state_q <= S_OUT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					div_z_q   <= div_z_q << 2;
					div_rem_q <= div_rem_nxt;
					div_quo_q <= div_quo_nxt;
					div_cnt_q <= div_cnt_q + DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(DIV_DIGITS - 1)) begin
						mac_req_q <= '{start: 1'b1, clear: 1'b1};
						state_q   <= S_RUN;
						if (op_q == OP_WM2) begin
							wm2_q   <= WW'(div_quo_nxt);
							mac_a_q <= AW'(r_w);
							mac_b_q <= BW'(sq_q);
							op_q    <= OP_WM1;
						end else begin
							// negative outer weights: negate the sample instead
							wp2_q   <= WW'(div_quo_nxt);
							mac_a_q <= -AW'(hist_q[3]);
							mac_b_q <= BW'(wm2_q);
							op_q    <= OP_H3;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || result_ch.ready) begin
						out_valid_q <= 1'b1;
						out_left_q  <= left_q;
						out_right_q <= right_q;
						out_last_q  <= last_w;
						phase_q     <= ph_next;
						n_q         <= n_next;
						state_q     <= last_w ? S_IDLE : S_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_ch.ready       = (state_q == S_IDLE);
	assign cfg_ch.ready          = 1'b1;
	assign result_ch.valid       = out_valid_q;
	assign result_ch.left_out    = out_left_q;
	assign result_ch.right_out   = out_right_q;
	assign result_ch.last_of_run = out_last_q;

	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RUN_W'(MAX_RUN))
		else $error("run counter beyond cap");

	a_mac_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == S_RUN)
		else $error("MAC finished outside the run state");

	a_phase_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START || state_q == S_RUN || state_q == S_DIV) |-> phase_q < ONE_PH)
		else $error("interpolating with phase at or above one");

	a_div_op: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> (op_q == OP_WM2 || op_q == OP_WP2))
		else $error("divider started by a wrong operation");

endmodule

// ----- tb/sv/cubic_interp_resampler_core_tb.sv -----
// Self-checking bench for cubic_interp_resampler_core: directed corners, random samples
// and register settings, output predicted in the bench and compared result by result.
// Depends on cir_pkg and cir_ifs (channel interfaces) and the resampler RTL.
module cubic_interp_resampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cir_pkg::*;

	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int FRAC_BITS   = FRAC_BITS_DEF;
	localparam int MAX_RUN     = MAX_RUN_DEF;

	localparam longint PHASE_ONE = longint'(1) << FRAC_BITS;
	localparam longint SAT_HI    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO    = -SAT_HI - 1;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;

	// pause after a drain covers a run still in flight
	localparam int SETTLE_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_ITEMS_END = 420;
	localparam int TAIL_ITEMS       = 60;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
		logic                          last;
	} stereo_result_t;

	logic clk = 1'b0;
	logic arst_n;

	cir_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch();
	cir_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch();
	cir_cfg_if cfg_ch();

	cubic_interp_resampler_core #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS(FRAC_BITS),
		.MAX_RUN(MAX_RUN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_ch(cfg_ch)
	);

	always #10 clk = ~clk;

	// predictor state: register shadows, sample history (0 is newest), phase
	logic [INC_W-1:0]  inc_shadow    = INC_RESET;
	logic [GAIN_W-1:0] gain_shadow   = GAIN_RESET;
	logic [PAN_W-1:0]  pan_shadow    = PAN_RESET;
	logic              stereo_shadow = STEREO_RESET;
	longint            sample_hist[4] = '{0, 0, 0, 0};
	longint            phase_acc = 0;

	stereo_result_t pending_outputs[$];

	int error_count  = 0;
	int idle_cycles  = 0;
	int items_sent   = 0;
	int stall_left   = 0;
	bit src_gaps_on  = 1'b0;
	bit sink_gaps_on = 1'b0;

	function automatic longint round_half_up(longint x, int sh);
		return (x + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic longint saturate_sample(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// |weight| = round(round(a*b/S) * c / (k*S))
	function automatic longint lagrange_weight(longint a, longint b, longint c, longint k);
		longint ab;
		longint den;
		ab  = (a * b + (PHASE_ONE >> 1)) >>> FRAC_BITS;
		den = k * PHASE_ONE;
		return (ab * c + den / 2) / den;
	endfunction

	function automatic void predict_resampled(logic signed [SAMPLE_BITS-1:0] s);
		longint inc;
		longint pan;
		longint t;
		longint acc;
		longint v;
		longint g;
		longint l;
		longint r;
		int n;
		stereo_result_t res;
		inc = (inc_shadow < MIN_INCREMENT) ? longint'(MIN_INCREMENT) : longint'(inc_shadow);
		pan = (pan_shadow > PAN_ONE) ? longint'(PAN_ONE) : longint'(pan_shadow);
		sample_hist[3] = sample_hist[2];
		sample_hist[2] = sample_hist[1];
		sample_hist[1] = sample_hist[0];
		sample_hist[0] = longint'(s);
		// below one on arrival (after reset or a capped run): restart at zero
		phase_acc = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : 0;
		n = 0;
		while (phase_acc < PHASE_ONE && n < MAX_RUN) begin
			t = phase_acc;
			acc = -lagrange_weight(t, PHASE_ONE - t, 2 * PHASE_ONE - t, 6) * sample_hist[3]
				+ lagrange_weight(PHASE_ONE + t, PHASE_ONE - t, 2 * PHASE_ONE - t, 2)
					* sample_hist[2]
				+ lagrange_weight(PHASE_ONE + t, t, 2 * PHASE_ONE - t, 2) * sample_hist[1]
				- lagrange_weight(PHASE_ONE + t, t, PHASE_ONE - t, 6) * sample_hist[0];
			v = round_half_up(acc, FRAC_BITS);
			g = round_half_up(v * longint'(gain_shadow), GAIN_SHIFT);
			if (stereo_shadow) begin
				l = saturate_sample(round_half_up(g * pan, PAN_SHIFT));
				r = saturate_sample(round_half_up(g * (longint'(PAN_ONE) - pan), PAN_SHIFT));
			end else begin
				l = saturate_sample(g);
				r = 0;
			end
			res.left  = l[SAMPLE_BITS-1:0];
			res.right = r[SAMPLE_BITS-1:0];
			res.last  = 1'b0;
			pending_outputs.push_back(res);
			phase_acc += inc;
			n++;
		end
		if (n > 0)
			pending_outputs[pending_outputs.size() - 1].last = 1'b1;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_PHASE_INCREMENT: inc_shadow = d[INC_W-1:0];
			REG_GAIN:            gain_shadow = d[GAIN_W-1:0];
			REG_PAN_LEFT:        pan_shadow = d[PAN_W-1:0];
			REG_STEREO_MODE:     stereo_shadow = d[0];
			default: ;
		endcase
	endfunction

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, longint got, longint want);
		if (got != want)
			report_error($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic check_result();
		stereo_result_t want;
		if (pending_outputs.size() == 0) begin
			report_error($sformatf("unexpected result left=%0d right=%0d last=%0b",
				result_ch.left_out, result_ch.right_out, result_ch.last_of_run));
		end else begin
			want = pending_outputs.pop_front();
			check_field("left_out", result_ch.left_out, want.left);
			check_field("right_out", result_ch.right_out, want.right);
			check_field("last_of_run", result_ch.last_of_run, want.last);
		end
	endtask

	// scoreboard and watchdog: every handshake on any channel counts as progress
	always @(posedge clk) begin
		bit progress;
		progress = 1'b0;
		if (result_ch.valid && result_ch.ready) begin
			progress = 1'b1;
			check_result();
		end
		if (sample_ch.valid && sample_ch.ready) begin
			progress = 1'b1;
			predict_resampled(sample_ch.sample_in);
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			progress = 1'b1;
			apply_register(cfg_ch.index, cfg_ch.data);
		end
		if (progress) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("cubic_interp_resampler_core_tb: done, errors");
				$finish;
			end
		end
	end

	// output backpressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (sink_gaps_on && $urandom_range(0, 11) == 0)
			stall_left = $urandom_range(1, 14);
		result_ch.ready <= (stall_left == 0);
	end

	task automatic push_sample(logic signed [SAMPLE_BITS-1:0] value);
		if (src_gaps_on && $urandom_range(0, 7) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_in <= value;
		do @(posedge clk); while (!sample_ch.ready);
		items_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, wait for every expected result, then let a run with no output settle;
	// the first clock wait lets the last accepted request be predicted
	task automatic finish_phase();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return SAMPLE_BITS'($urandom_range(0, 4000) - 2000);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	task automatic test_sample_extremes();
		push_sample('0);
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MIN);
		push_sample(SAMPLE_MAX);
		push_sample('1);
		push_sample(SAMPLE_BITS'(1));
		push_sample(SAMPLE_BITS'(24'h555555));
		push_sample(SAMPLE_BITS'(24'hAAAAAA));
		finish_phase();
	endtask

	task automatic test_register_corners();
		// increment below the floor, gain max, pan wider than one -> saturation
		write_reg(REG_PHASE_INCREMENT, '0);
		write_reg(REG_GAIN, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_PAN_LEFT, '1);
		write_reg(REG_STEREO_MODE, CFG_DATA_W'(1));
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MIN);
		push_sample(SAMPLE_MAX);
		push_sample('0);
		finish_phase();
		// largest increment: most inputs give nothing, phase underflow follows
		write_reg(REG_PHASE_INCREMENT, '1);
		write_reg(REG_GAIN, '0);
		write_reg(REG_PAN_LEFT, '0);
		write_reg(REG_STEREO_MODE, '0);
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MIN);
		push_sample('1);
		finish_phase();
		// unmapped index is dropped; upper data bits beyond a register are ignored
		write_reg(REG_UNMAPPED, '1);
		write_reg(REG_PHASE_INCREMENT, CFG_DATA_W'(INC_RESET));
		write_reg(REG_GAIN, {4'hF, GAIN_RESET});
		write_reg(REG_PAN_LEFT, {3'h7, PAN_W'(0)});
		write_reg(REG_STEREO_MODE, CFG_DATA_W'(20'hFFFFE));
		push_sample(SAMPLE_MIN);
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_BITS'(12345));
		finish_phase();
	endtask

	task automatic test_random_settings();
		int unsigned inc_val;
		int unsigned gain_val;
		int unsigned pan_val;
		int phase_items;
		while (items_sent < RANDOM_ITEMS_END) begin
			src_gaps_on  = ($urandom_range(0, 3) != 0);
			sink_gaps_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: inc_val = $urandom_range(0, 2047);
				1: inc_val = $urandom_range(2048, 8191);
				2: inc_val = $urandom_range(131072, 1048575);
				default: inc_val = $urandom_range(16384, 196608);
			endcase
			// small increments give long runs, so keep those phases short
			phase_items = (inc_val < 8192) ? 6 : 40;
			case ($urandom_range(0, 5))
				0: gain_val = 0;
				1: gain_val = 65535;
				default: gain_val = $urandom_range(0, 65535);
			endcase
			case ($urandom_range(0, 7))
				0: pan_val = 0;
				1: pan_val = 65536;
				2: pan_val = $urandom_range(65537, 131071);
				default: pan_val = $urandom_range(0, 65536);
			endcase
			write_reg(REG_PHASE_INCREMENT, inc_val[INC_W-1:0]);
			write_reg(REG_GAIN, {4'($urandom()), gain_val[GAIN_W-1:0]});
			write_reg(REG_PAN_LEFT, {3'($urandom()), pan_val[PAN_W-1:0]});
			write_reg(REG_STEREO_MODE, CFG_DATA_W'($urandom()));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_STEREO_MODE + 1, 15)),
					CFG_DATA_W'($urandom()));
			repeat (phase_items) push_sample(random_sample());
			finish_phase();
		end
	endtask

	task automatic test_steady_stream();
		src_gaps_on  = 1'b0;
		sink_gaps_on = 1'b0;
		write_reg(REG_PHASE_INCREMENT, CFG_DATA_W'($urandom_range(40000, 100000)));
		write_reg(REG_GAIN, CFG_DATA_W'(GAIN_RESET));
		write_reg(REG_PAN_LEFT, CFG_DATA_W'($urandom_range(0, 65536)));
		write_reg(REG_STEREO_MODE, CFG_DATA_W'(STEREO_RESET));
		repeat (TAIL_ITEMS) push_sample(random_sample());
		finish_phase();
	endtask

	initial begin
		arst_n              <= 1'b0;
		sample_ch.valid     <= 1'b0;
		sample_ch.sample_in <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_PHASE_INCREMENT;
		cfg_ch.data         <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sample_extremes();
		test_register_corners();
		test_random_settings();
		test_steady_stream();

		if (error_count == 0)
			$display("cubic_interp_resampler_core_tb: done, clean");
		else
			$display("cubic_interp_resampler_core_tb: done, errors");
		$finish;
	end

endmodule
